FILE: rtl/core/psse_pkg.sv
// Shared types, constants and the CRC-32 byte step for the PNG stored-RGB8 stream encoder.
// Used by every module of the block; it depends on nothing else.
package psse_pkg;

	localparam int unsigned CFG_W      = 13;
	localparam logic [12:0] MAX_WIDTH  = 13'd4096;
	localparam logic [12:0] MAX_HEIGHT = 13'd4096;
	localparam logic [15:0] BLOCK_MAX  = 16'd65535;
	localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
	localparam logic [31:0] ALL_ONES   = 32'hFFFFFFFF;
	localparam logic [16:0] ADLER_MOD  = 17'd65521;

	localparam logic [5:0] HEAD_LAST = 6'd42;
	localparam logic [5:0] BLK_LAST  = 6'd4;
	localparam logic [5:0] TRL_LAST  = 6'd19;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_PIXEL = 2'd1,
		CMD_BAD   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_beat_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_HEAD = 6'b000010,
		ST_BLK  = 6'b000100,
		ST_RAW  = 6'b001000,
		ST_TRL  = 6'b010000,
		ST_ERR  = 6'b100000
	} state_t;

	function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] r;
		r = crc ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/psse_item_if.sv
// Input channel of the encoder: valid/ready handshake and one item per beat.
// Stands alone; no package needed.
interface psse_item_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, req_type, red, green, blue, input ready);
	modport sink(input valid, req_type, red, green, blue, output ready);
endinterface

FILE: rtl/core/psse_result_if.sv
// Output channel of the encoder: valid/ready handshake and one stream byte per beat.
// Stands alone; no package needed.
interface psse_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic       error;

	modport source(output valid, out_byte, last, error, input ready);
	modport sink(input valid, out_byte, last, error, output ready);
endinterface

FILE: rtl/core/psse_front.sv
// Front end: takes input beats while the command queue has room and classifies each one.
// Depends on psse_pkg and psse_item_if.
module psse_front (
	psse_item_if.sink              item,
	input  logic [12:0]            image_width,
	input  logic [12:0]            image_height,
	input  logic                   full,
	output psse_pkg::cmd_beat_t    push
);

	logic dims_ok;

	assign dims_ok = (image_width != '0) && (image_height != '0) &&
		(image_width <= psse_pkg::MAX_WIDTH) && (image_height <= psse_pkg::MAX_HEIGHT);

	assign item.ready = !full;

	always_comb begin
		push.valid     = item.valid && !full;
		push.cmd.red   = item.red;
		push.cmd.green = item.green;
		push.cmd.blue  = item.blue;
		if (item.req_type) begin
			push.cmd.kind = psse_pkg::CMD_PIXEL;
		end else if (dims_ok) begin
			push.cmd.kind = psse_pkg::CMD_START;
		end else begin
			push.cmd.kind = psse_pkg::CMD_BAD;
		end
	end

endmodule

FILE: rtl/core/psse_cmd_fifo.sv
// Two-entry command queue between the front end and the byte sequencer.
// Depends on psse_pkg.
module psse_cmd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  psse_pkg::cmd_beat_t  push,
	output logic                 full,
	output psse_pkg::cmd_beat_t  head,
	input  logic                 pop
);

	psse_pkg::cmd_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_pop;

	assign full       = count_q == 2'd2;
	assign head.valid = count_q != 2'd0;
	assign head.cmd   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push.valid} - {1'b0, do_pop};
		end
	end

endmodule

FILE: rtl/core/psse_back.sv
// Byte sequencer: walks headers, stored-block headers, pixel bytes and the trailer,
// keeping the chunk CRC and Adler-32. Depends on psse_pkg and psse_result_if.
module psse_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [12:0]          image_width,
	input  logic [12:0]          image_height,
	input  psse_pkg::cmd_beat_t  head,
	output logic                 pop,
	psse_result_if.source        result
);

	psse_pkg::state_t st_q, cur_st, nxt_st;
	logic [5:0]  idx_q, cur_idx, nxt_idx;
	logic [1:0]  rb_q, cur_rb, nxt_rb;
	logic [7:0]  red_q, green_q, blue_q;
	logic [7:0]  cur_red, cur_green, cur_blue;
	logic [31:0] crc_q;
	logic [15:0] alow_q, ahigh_q;
	logic [12:0] col_q;
	logic [15:0] blk_left_q;
	logic [27:0] raw_left_q;
	logic        active_q;
	logic        ovalid_q;
	logic [7:0]  obyte_q;
	logic        olast_q, oerr_q;

	// Frame size arithmetic, registered step by step during the signature bytes.
	logic [27:0] raw_s1;
	logic [12:0] blocks_s2;
	logic [31:0] len_s3;
	logic [28:0] ceil_x;
	logic [16:0] ceil_r;
	logic [14:0] w3p1;

	logic        adv;
	logic [7:0]  byte_c;
	logic        fold, crc_rst, last_c, err_c, emit;
	logic [15:0] blk_c;
	logic [7:0]  raw_v;
	logic [16:0] lo_sum, hi_sum;
	logic [15:0] lo_n, hi_n;
	logic [31:0] crc_fin;
	logic [31:0] crc_src;

	assign w3p1   = {2'b00, image_width} + {1'b0, image_width, 1'b0} + 15'd1;
	assign ceil_x = {1'b0, raw_s1} + 29'(psse_pkg::BLOCK_MAX - 16'd1);
	assign ceil_r = {1'b0, ceil_x[15:0]} + {4'b0000, ceil_x[28:16]};

	always_ff @(posedge clk) begin
		raw_s1    <= 28'(image_height * w3p1);
		blocks_s2 <= ceil_x[28:16] + {12'd0, ceil_r >= {1'b0, psse_pkg::BLOCK_MAX}};
		len_s3    <= {4'h0, raw_s1} + {17'd0, blocks_s2, 2'b00} + {19'd0, blocks_s2} + 32'd6;
	end

	assign adv = !ovalid_q || result.ready;
	assign pop = adv && (st_q == psse_pkg::ST_IDLE) && head.valid;

	// A new command is dispatched in the same cycle it is popped.
	always_comb begin
		cur_st    = st_q;
		cur_idx   = idx_q;
		cur_rb    = rb_q;
		cur_red   = red_q;
		cur_green = green_q;
		cur_blue  = blue_q;
		if (st_q == psse_pkg::ST_IDLE && head.valid) begin
			cur_idx   = '0;
			cur_rb    = (col_q == '0) ? 2'd0 : 2'd1;
			cur_red   = head.cmd.red;
			cur_green = head.cmd.green;
			cur_blue  = head.cmd.blue;
			case (head.cmd.kind)
				psse_pkg::CMD_START: cur_st = psse_pkg::ST_HEAD;
				psse_pkg::CMD_PIXEL: begin
					if (!active_q) begin
						cur_st = psse_pkg::ST_ERR;
					end else if (blk_left_q == '0) begin
						cur_st = psse_pkg::ST_BLK;
					end else begin
						cur_st = psse_pkg::ST_RAW;
					end
				end
				default: cur_st = psse_pkg::ST_ERR;
			endcase
		end
	end

	assign blk_c   = (raw_left_q > {12'd0, psse_pkg::BLOCK_MAX}) ? psse_pkg::BLOCK_MAX
		: raw_left_q[15:0];
	assign crc_fin = crc_q ^ psse_pkg::ALL_ONES;

	always_comb begin
		case (cur_rb)
			2'd0:    raw_v = 8'h00;
			2'd1:    raw_v = cur_red;
			2'd2:    raw_v = cur_green;
			default: raw_v = cur_blue;
		endcase
	end

	assign lo_sum = {1'b0, alow_q} + {9'd0, raw_v};
	assign lo_n   = (lo_sum >= psse_pkg::ADLER_MOD) ? 16'(lo_sum - psse_pkg::ADLER_MOD)
		: lo_sum[15:0];
	assign hi_sum = {1'b0, ahigh_q} + {1'b0, lo_n};
	assign hi_n   = (hi_sum >= psse_pkg::ADLER_MOD) ? 16'(hi_sum - psse_pkg::ADLER_MOD)
		: hi_sum[15:0];

	always_comb begin
		byte_c  = 8'h00;
		fold    = 1'b0;
		crc_rst = 1'b0;
		last_c  = 1'b0;
		err_c   = 1'b0;
		emit    = 1'b1;
		nxt_st  = cur_st;
		nxt_idx = cur_idx + 6'd1;
		nxt_rb  = cur_rb;
		unique case (cur_st)
			psse_pkg::ST_HEAD: begin
				case (cur_idx)
					6'd0:  byte_c = 8'h89;
					6'd1:  byte_c = 8'h50;
					6'd2:  byte_c = 8'h4E;
					6'd3:  byte_c = 8'h47;
					6'd4:  byte_c = 8'h0D;
					6'd5:  byte_c = 8'h0A;
					6'd6:  byte_c = 8'h1A;
					6'd7:  byte_c = 8'h0A;
					6'd11: byte_c = 8'h0D;
					6'd12: byte_c = 8'h49;
					6'd13: byte_c = 8'h48;
					6'd14: byte_c = 8'h44;
					6'd15: byte_c = 8'h52;
					6'd18: byte_c = {3'b000, image_width[12:8]};
					6'd19: byte_c = image_width[7:0];
					6'd22: byte_c = {3'b000, image_height[12:8]};
					6'd23: byte_c = image_height[7:0];
					6'd24: byte_c = 8'h08;
					6'd25: byte_c = 8'h02;
					6'd29: byte_c = crc_fin[31:24];
					6'd30: byte_c = crc_fin[23:16];
					6'd31: byte_c = crc_fin[15:8];
					6'd32: byte_c = crc_fin[7:0];
					6'd33: byte_c = len_s3[31:24];
					6'd34: byte_c = len_s3[23:16];
					6'd35: byte_c = len_s3[15:8];
					6'd36: byte_c = len_s3[7:0];
					6'd37: byte_c = 8'h49;
					6'd38: byte_c = 8'h44;
					6'd39: byte_c = 8'h41;
					6'd40: byte_c = 8'h54;
					6'd41: byte_c = 8'h78;
					6'd42: byte_c = 8'h01;
					default: byte_c = 8'h00;
				endcase
				fold    = (cur_idx >= 6'd12 && cur_idx <= 6'd28) || (cur_idx >= 6'd37);
				crc_rst = (cur_idx == 6'd12) || (cur_idx == 6'd37);
				if (cur_idx == psse_pkg::HEAD_LAST) begin
					last_c = 1'b1;
					nxt_st = psse_pkg::ST_IDLE;
				end
			end
			psse_pkg::ST_BLK: begin
				fold = 1'b1;
				case (cur_idx[2:0])
					3'd0:    byte_c = {7'd0, raw_left_q <= {12'd0, psse_pkg::BLOCK_MAX}};
					3'd1:    byte_c = blk_c[7:0];
					3'd2:    byte_c = blk_c[15:8];
					3'd3:    byte_c = ~blk_c[7:0];
					default: byte_c = ~blk_c[15:8];
				endcase
				if (cur_idx == psse_pkg::BLK_LAST) begin
					nxt_st  = psse_pkg::ST_RAW;
					nxt_idx = '0;
				end
			end
			psse_pkg::ST_RAW: begin
				fold    = 1'b1;
				byte_c  = raw_v;
				nxt_idx = '0;
				if (raw_left_q == 28'd1) begin
					nxt_st = psse_pkg::ST_TRL;
				end else if (cur_rb == 2'd3) begin
					last_c = 1'b1;
					nxt_st = psse_pkg::ST_IDLE;
				end else begin
					nxt_rb = cur_rb + 2'd1;
					nxt_st = (blk_left_q == 16'd1) ? psse_pkg::ST_BLK : psse_pkg::ST_RAW;
				end
			end
			psse_pkg::ST_TRL: begin
				case (cur_idx)
					6'd0:  byte_c = ahigh_q[15:8];
					6'd1:  byte_c = ahigh_q[7:0];
					6'd2:  byte_c = alow_q[15:8];
					6'd3:  byte_c = alow_q[7:0];
					6'd4:  byte_c = crc_fin[31:24];
					6'd5:  byte_c = crc_fin[23:16];
					6'd6:  byte_c = crc_fin[15:8];
					6'd7:  byte_c = crc_fin[7:0];
					6'd12: byte_c = 8'h49;
					6'd13: byte_c = 8'h45;
					6'd14: byte_c = 8'h4E;
					6'd15: byte_c = 8'h44;
					6'd16: byte_c = crc_fin[31:24];
					6'd17: byte_c = crc_fin[23:16];
					6'd18: byte_c = crc_fin[15:8];
					6'd19: byte_c = crc_fin[7:0];
					default: byte_c = 8'h00;
				endcase
				fold    = (cur_idx <= 6'd3) || (cur_idx >= 6'd12 && cur_idx <= 6'd15);
				crc_rst = cur_idx == 6'd12;
				if (cur_idx == psse_pkg::TRL_LAST) begin
					last_c = 1'b1;
					nxt_st = psse_pkg::ST_IDLE;
				end
			end
			psse_pkg::ST_ERR: begin
				last_c = 1'b1;
				err_c  = 1'b1;
				nxt_st = psse_pkg::ST_IDLE;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign crc_src = crc_rst ? psse_pkg::ALL_ONES : crc_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			red_q   <= head.cmd.red;
			green_q <= head.cmd.green;
			blue_q  <= head.cmd.blue;
		end
		if (adv && emit) begin
			obyte_q <= byte_c;
			olast_q <= last_c;
			oerr_q  <= err_c;
			idx_q   <= nxt_idx;
			rb_q    <= nxt_rb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= psse_pkg::ST_IDLE;
			ovalid_q   <= 1'b0;
			crc_q      <= psse_pkg::ALL_ONES;
			alow_q     <= 16'd1;
			ahigh_q    <= 16'd0;
			col_q      <= '0;
			blk_left_q <= '0;
			raw_left_q <= '0;
			active_q   <= 1'b0;
		end else if (adv) begin
			ovalid_q <= emit;
			if (emit) begin
				st_q <= nxt_st;
			end
			if (fold) begin
				crc_q <= psse_pkg::crc_byte(crc_src, byte_c);
			end
			if (cur_st == psse_pkg::ST_HEAD || cur_st == psse_pkg::ST_ERR) begin
				active_q <= 1'b0;
			end
			if (cur_st == psse_pkg::ST_HEAD && cur_idx == psse_pkg::HEAD_LAST) begin
				active_q   <= 1'b1;
				alow_q     <= 16'd1;
				ahigh_q    <= 16'd0;
				col_q      <= '0;
				blk_left_q <= '0;
				raw_left_q <= raw_s1;
			end
			if (cur_st == psse_pkg::ST_BLK && cur_idx == psse_pkg::BLK_LAST) begin
				blk_left_q <= blk_c;
			end
			if (cur_st == psse_pkg::ST_RAW) begin
				alow_q     <= lo_n;
				ahigh_q    <= hi_n;
				blk_left_q <= blk_left_q - 16'd1;
				raw_left_q <= raw_left_q - 28'd1;
				if (raw_left_q == 28'd1) begin
					active_q <= 1'b0;
				end else if (cur_rb == 2'd3) begin
					// Row break follows the live width register.
					col_q <= ({1'b0, col_q} + 14'd1 >= {1'b0, image_width}) ? '0
						: col_q + 13'd1;
				end
			end
		end
	end

	assign result.valid    = ovalid_q;
	assign result.out_byte = obyte_q;
	assign result.last     = olast_q;
	assign result.error    = oerr_q;

endmodule

FILE: rtl/core/png_stored_rgb8_stream_encoder_unit.sv
// PNG stream encoder for 8-bit RGB rasters using stored (uncompressed) deflate blocks.
// Input beats on "item": req_type 0 starts a frame, 1 delivers one pixel (red, green, blue).
// Output beats on "result": one PNG byte each; last marks the final byte of an item,
// error marks a rejected item (byte zero). Width and height are set over the APB port
// at byte addresses 0 and 4 by the user, only while the block is idle; the block itself
// does not enforce this. With the sequencer idle, a taken beat is written into the
// command queue, then popped, and the item's first byte is registered for output.
// Output size: a start gives 43 bytes, a rejected item 1, a pixel 3 bytes (4 at a row
// start), plus 5 bytes per stored-block header and 20 for the trailer at frame end.
// The byte sequencer emits one byte per cycle while the receiver is ready; a two-entry
// command queue lets the input side keep taking items while the sequencer works or waits.
// Reset clears the queue, the sequencer and any open frame; width and height return to 1.
// When the receiver stalls, the output byte holds, the sequencer freezes, and the input
// side stops taking items once the queue is full.
// Depends on psse_pkg, psse_item_if, psse_result_if, psse_front, psse_cmd_fifo, psse_back.
module png_stored_rgb8_stream_encoder_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	psse_item_if.sink     item,
	psse_result_if.source result
);

	logic [12:0]         width_q;
	logic [12:0]         height_q;
	logic                full;
	logic                pop;
	psse_pkg::cmd_beat_t push;
	psse_pkg::cmd_beat_t head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == psse_pkg::REG_HEIGHT) ? {19'd0, height_q} : {19'd0, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd1;
			height_q <= 13'd1;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == psse_pkg::REG_WIDTH) begin
				width_q <= pwdata[psse_pkg::CFG_W-1:0];
			end else begin
				height_q <= pwdata[psse_pkg::CFG_W-1:0];
			end
		end
	end

	psse_front u_front (
		.item         (item),
		.image_width  (width_q),
		.image_height (height_q),
		.full         (full),
		.push         (push)
	);

	psse_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.head   (head),
		.pop    (pop)
	);

	psse_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (width_q),
		.image_height (height_q),
		.head         (head),
		.pop          (pop),
		.result       (result)
	);

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the PNG stored-RGB8 stream encoder: random and directed frames,
// predicted byte by byte by an in-bench scoreboard. Depends on psse_pkg, psse_item_if,
// psse_result_if and png_stored_rgb8_stream_encoder_unit.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	typedef struct {
		logic [7:0] data;
		logic       lst;
		logic       err;
	} png_byte_t;

	// Scoreboard: tracks encoder state and holds the bytes still owed by the block.
	class png_scoreboard;
		logic [12:0] width_r = 13'd1;
		logic [12:0] height_r = 13'd1;
		logic [31:0] crc = psse_pkg::ALL_ONES;
		logic [31:0] a_lo = 32'd1;
		logic [31:0] a_hi = 32'd0;
		logic [15:0] col = '0;
		logic [15:0] row = '0;
		logic [31:0] blk_left = '0;
		logic [31:0] raw_left = '0;
		bit          active = 0;
		png_byte_t   owed[$];
		int          fails = 0;
		int          bytes_seen = 0;
		int          frames_done = 0;

		function void put(logic [7:0] b, logic e = 1'b0);
			png_byte_t x;
			x.data = b;
			x.lst = 1'b0;
			x.err = e;
			owed.insert(owed.size(), x);
		endfunction

		function void put_crc(logic [7:0] b);
			put(b);
			crc = crc ^ {24'h0, b};
			for (int k = 0; k < 8; k++)
				crc = crc[0] ? ((crc >> 1) ^ 32'hEDB88320) : (crc >> 1);
		endfunction

		function void put_word(logic [31:0] v, bit with_crc);
			for (int s = 24; s >= 0; s -= 8) begin
				if (with_crc) put_crc(v[s +: 8]);
				else put(v[s +: 8]);
			end
		endfunction

		function void put_tag(string t);
			for (int i = 0; i < 4; i++) put_crc(t[i]);
		endfunction

		function void put_raw(logic [7:0] v);
			logic [31:0] blk;
			if (!active) return;
			if (blk_left == 0) begin
				blk = (raw_left > 32'd65535) ? 32'd65535 : raw_left;
				put_crc((blk == raw_left) ? 8'd1 : 8'd0);
				put_crc(blk[7:0]);
				put_crc(blk[15:8]);
				put_crc(~blk[7:0]);
				put_crc(~blk[15:8]);
				blk_left = blk;
			end
			put_crc(v);
			a_lo = (a_lo + v) % 65521;
			a_hi = (a_hi + a_lo) % 65521;
			blk_left--;
			raw_left--;
			if (raw_left == 0) begin
				put_word({a_hi[15:0], a_lo[15:0]}, 1);
				put_word(crc ^ psse_pkg::ALL_ONES, 0);
				put_word(32'd0, 0);
				crc = psse_pkg::ALL_ONES;
				put_tag("IEND");
				put_word(crc ^ psse_pkg::ALL_ONES, 0);
				active = 0;
				frames_done++;
			end
		endfunction

		function void start_frame();
			logic [31:0] raw;
			logic [31:0] blocks;
			logic [7:0] sig[8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
			active = 0;
			if (width_r == 0 || height_r == 0 || width_r > psse_pkg::MAX_WIDTH ||
				height_r > psse_pkg::MAX_HEIGHT) begin
				put(8'h00, 1'b1);
				return;
			end
			raw = height_r * (width_r * 3 + 1);
			blocks = (raw + 65534) / 65535;
			foreach (sig[i]) put(sig[i]);
			put_word(32'd13, 0);
			crc = psse_pkg::ALL_ONES;
			put_tag("IHDR");
			put_word({19'd0, width_r}, 1);
			put_word({19'd0, height_r}, 1);
			put_crc(8'd8);
			put_crc(8'd2);
			put_crc(8'd0);
			put_crc(8'd0);
			put_crc(8'd0);
			put_word(crc ^ psse_pkg::ALL_ONES, 0);
			put_word(2 + raw + 5 * blocks + 4, 0);
			crc = psse_pkg::ALL_ONES;
			put_tag("IDAT");
			put_crc(8'h78);
			put_crc(8'h01);
			a_lo = 1;
			a_hi = 0;
			col = 0;
			row = 0;
			blk_left = 0;
			raw_left = raw;
			active = 1;
		endfunction

		// Called once per accepted input beat.
		function void note_item(logic req, logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int first;
			first = owed.size();
			if (req == REQ_START) start_frame();
			else if (!active) put(8'h00, 1'b1);
			else begin
				if (col == 0) put_raw(8'h00);
				put_raw(r);
				put_raw(g);
				put_raw(b);
				col = col + 1;
				if (col >= {3'd0, width_r}) begin
					col = 0;
					row = row + 1;
				end
			end
			if (owed.size() > first) owed[owed.size() - 1].lst = 1'b1;
		endfunction

		function void check_byte(logic [7:0] b, logic l, logic e);
			png_byte_t x;
			bytes_seen++;
			if (owed.size() == 0) begin
				$error("unexpected output beat: out_byte=%0h last=%0b error=%0b", b, l, e);
				fails++;
				return;
			end
			x = owed.pop_front();
			if (b !== x.data) begin
				$error("out_byte: expected %0h, got %0h", x.data, b);
				fails++;
			end
			if (l !== x.lst) begin
				$error("last: expected %0b, got %0b", x.lst, l);
				fails++;
			end
			if (e !== x.err) begin
				$error("error: expected %0b, got %0b", x.err, e);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	bit calm = 0;
	int items_sent = 0;
	png_scoreboard sb = new();

	psse_item_if item_ch();
	psse_result_if res_ch();

	png_stored_rgb8_stream_encoder_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item(item_ch), .result(res_ch)
	);

	always #6 clk = ~clk;

	initial begin
		item_ch.valid = 1'b0;
		item_ch.req_type = 1'b0;
		item_ch.red = '0;
		item_ch.green = '0;
		item_ch.blue = '0;
		res_ch.ready = 1'b0;
	end

	// Receiver: ready alternates in random bursts unless the run is in its calm tail.
	int hold = 0;
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_byte(res_ch.out_byte, res_ch.last, res_ch.error);
		if (calm) begin
			res_ch.ready <= 1'b1;
		end else if (hold > 0) begin
			hold <= hold - 1;
		end else begin
			res_ch.ready <= ($urandom_range(0, 2) != 0);
			hold <= $urandom_range(1, 16) - 1;
		end
	end

	task automatic send(logic req, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		if (!calm && $urandom_range(0, 5) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.req_type <= req;
		item_ch.red <= r;
		item_ch.green <= g;
		item_ch.blue <= b;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		sb.note_item(req, r, g, b);
		items_sent++;
	endtask

	task automatic send_pixel_rand();
		send(REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Drain all owed bytes, then give the sequencer time to settle before a register write.
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] v);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == psse_pkg::REG_WIDTH) sb.width_r = v[12:0];
		else sb.height_r = v[12:0];
	endtask

	task automatic set_size(int w, int h);
		write_reg(psse_pkg::REG_WIDTH, w);
		write_reg(psse_pkg::REG_HEIGHT, h);
	endtask

	initial begin
		int w;
		int h;
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size 1x1: pixel with no frame, a one-pixel frame, then a stray pixel.
		send(REQ_PIXEL, 8'h12, 8'h34, 8'h56);
		send(REQ_START, 8'hFF, 8'hFF, 8'hFF);
		send(REQ_PIXEL, 8'h00, 8'h00, 8'h00);
		send(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);

		// Bad dimensions, and the largest legal frame opened and then abandoned.
		set_size(0, 1);
		send(REQ_START, 8'h00, 8'h00, 8'h00);
		set_size(4097, 4096);
		send(REQ_START, 8'h00, 8'h00, 8'h00);
		set_size(8191, 8191);
		send(REQ_START, 8'h00, 8'h00, 8'h00);
		set_size(4096, 4096);
		send(REQ_START, 8'h00, 8'h00, 8'h00);
		send(REQ_PIXEL, 8'hFF, 8'h00, 8'hFF);
		set_size(4096, 0);
		send(REQ_START, 8'h00, 8'h00, 8'h00);
		send(REQ_PIXEL, 8'h01, 8'h02, 8'h03);

		// 3x2 frame restarted mid-way, then finished with extreme bytes.
		set_size(3, 2);
		send(REQ_START, 8'h00, 8'h00, 8'h00);
		send(REQ_PIXEL, 8'h5A, 8'hA5, 8'h5A);
		send(REQ_START, 8'h00, 8'h00, 8'h00);
		for (int i = 0; i < 6; i++)
			send(REQ_PIXEL, (i % 2) ? 8'hFF : 8'h00, 8'hA5, (i % 2) ? 8'h00 : 8'hFF);

		// Width shrinks mid-frame: row breaks move and the last pixel loses its tail byte.
		set_size(3, 1);
		send(REQ_START, 8'h00, 8'h00, 8'h00);
		send_pixel_rand();
		write_reg(psse_pkg::REG_WIDTH, 1);
		send_pixel_rand();
		send_pixel_rand();
		send_pixel_rand();

		// Random small frames: mostly complete, some cut short or overrun, some noise.
		while (items_sent < 440) begin
			w = $urandom_range(1, 6);
			h = $urandom_range(1, 4);
			if ($urandom_range(0, 15) == 0) w = 0;
			if ($urandom_range(0, 15) == 0) h = $urandom_range(4097, 8191);
			set_size(w, h);
			if ($urandom_range(0, 7) == 0) send_pixel_rand();
			send(REQ_START, 8'($urandom), 8'($urandom), 8'($urandom));
			n = w * h;
			case ($urandom_range(0, 7))
				0: n = $urandom_range(0, n);
				1: n = n + $urandom_range(1, 3);
				default: ;
			endcase
			for (int i = 0; i < n; i++) send_pixel_rand();
		end

		// Calm tail: one complete frame sent back to back with the receiver always ready.
		set_size(5, 3);
		calm = 1;
		send(REQ_START, 8'h00, 8'h00, 8'h00);
		for (int i = 0; i < 5 * 3; i++) send_pixel_rand();

		drain();
		$display("Sent %0d items and checked %0d stream bytes; %0d frames completed.",
			items_sent, sb.bytes_seen, sb.frames_done);
		if (sb.fails == 0 && sb.owed.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#200ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
